// ===== hw/rtl/mse_pkg.sv =====
// Package for mips_subset_execute: opcode and function codes, result status codes, instruction and result structs.
// No dependencies.
package mse_pkg;
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_BGTZ  = 6'd7;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_NORI  = 6'd14;
    localparam logic [5:0] OP_LUI   = 6'd15;
    localparam logic [5:0] OP_LB    = 6'd32;
    localparam logic [5:0] OP_LH    = 6'd33;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_LBU   = 6'd36;
    localparam logic [5:0] OP_LHU   = 6'd37;
    localparam logic [5:0] OP_SB    = 6'd40;
    localparam logic [5:0] OP_SH    = 6'd41;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] OP_HALT  = 6'd63;

    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_SRA  = 6'd3;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_XOR  = 6'd38;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_NAND = 6'd40;
    localparam logic [5:0] FN_SLT  = 6'd42;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [4:0] LINK_REG = 5'd31;
    localparam logic [31:0] REGION_MASK = 32'hF000_0000;

    // last member in the lowest bits, matching the tdata layout
    typedef struct packed {
        logic [25:0] target;
        logic [15:0] imm16;
        logic [4:0]  shamt;
        logic [4:0]  rd;
        logic [4:0]  rt;
        logic [4:0]  rs;
        logic [5:0]  func;
        logic [5:0]  mode;
    } instr_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_write;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic [31:0] pc_value;
    } result_t;
endpackage

// ===== hw/rtl/mse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/mips_subset_execute.sv =====
// Executes one MIPS-subset instruction per word.
// Pipeline: the accepted word is registered (decode/read), then executed into the output register.
// Throughput: one word per cycle while the output is not stalled; operand and memory hazards forwarded.
// Memory: four byte-lane RAMs, one read port each, registered read.
// Reset: clears pc, control and starts a memory sweep over all DATA_BYTES/4 rows (no input taken meanwhile);
// registers clear via valid bits.
module mips_subset_execute #(
    parameter int DATA_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode, func, rs, rt, rd, shamt, imm16, target from bit 0 up: 74 bits used
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, reg_write, dest_reg, dest_value, pc_value from bit 0 up: 72 bits used
    output logic [79:0] m_tdata
);
    import mse_pkg::*;

    localparam int AW   = $clog2(DATA_BYTES);
    localparam int LW   = (AW > 2) ? AW - 2 : 1;
    localparam int ROWS = DATA_BYTES / 4;

    // ---------------- config ----------------
    logic [31:0] initial_pc_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? initial_pc_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            initial_pc_reg <= 32'd0;
        else if (cfg_wr)
            initial_pc_reg <= pwdata;
    end

    // ---------------- clear sweep ----------------
    logic          clr_reg;
    logic [LW:0]   clr_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (LW+1)'(ROWS - 1))
                clr_reg <= 1'b0;
        end
    end

    // ---------------- stage 1: capture ----------------
    instr_t s_in;
    assign s_in = s_tdata[73:0];

    logic   ex_valid_reg;
    instr_t ex_reg;
    logic   stall;
    logic   out_full_reg;
    result_t out_reg;

    assign stall    = out_full_reg && !m_tready;
    assign s_tready = !clr_reg && !stall;

    logic accept;
    assign accept = s_tvalid && s_tready;

    // ---------------- register file (flops with valid bits) ----------------
    logic [31:0] rf_reg [32];
    logic [31:0] rf_vld_reg;

    // ---------------- execute stage ----------------
    logic [31:0] pc_reg;
    logic [31:0] a, b, simm, zimm, addr, pc4, pc_next, val;
    logic        wr, is_store, exec;
    logic [1:0]  status;
    logic [4:0]  dst;
    logic [2:0]  nbytes;
    logic [31:0] ld_raw;

    assign a    = (ex_reg.rs != 5'd0 && rf_vld_reg[ex_reg.rs]) ? rf_reg[ex_reg.rs] : 32'd0;
    assign b    = (ex_reg.rt != 5'd0 && rf_vld_reg[ex_reg.rt]) ? rf_reg[ex_reg.rt] : 32'd0;
    assign zimm = {16'd0, ex_reg.imm16};
    assign simm = {{16{ex_reg.imm16[15]}}, ex_reg.imm16};
    assign addr = a + simm;
    assign pc4  = pc_reg + 32'd4;
    assign exec = ex_valid_reg && !stall;

    // memory: lane k holds byte addresses with addr%4==k; row = addr>>2
    // the load address of the accepted word is formed in stage 1 so its bytes
    // arrive together with the word in the execute stage
    logic [AW-1:0] s1_addr;
    logic [31:0]   s1_a;
    logic [31:0]   s1_simm;
    assign s1_simm = {{16{s_in.imm16[15]}}, s_in.imm16};

    // operand a for the accepted word, forwarding the executing word's write
    always_comb
    begin
        s1_a = (s_in.rs != 5'd0 && rf_vld_reg[s_in.rs]) ? rf_reg[s_in.rs] : 32'd0;
        if (exec && wr && dst != 5'd0 && dst == s_in.rs)
            s1_a = val;
    end
    assign s1_addr = AW'(s1_a + s1_simm);

    // without a new word, keep reading the bytes of the word held in execute
    logic [AW-1:0] rd_base;
    assign rd_base = accept ? s1_addr : AW'(addr);

    logic [LW-1:0] rd_row [4];
    logic [7:0]    rd_byte [4];
    logic [LW-1:0] wr_row [4];
    logic [7:0]    wr_byte [4];
    logic [3:0]    wr_en;

    // per-byte read addresses (byte k at rd_base + k)
    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        logic [AW-1:0] ra;
        logic [AW-1:0] wa;
        logic [LW-1:0] wrow_mux;
        always_comb
        begin
            // find which of 4 consecutive bytes lands in lane l
            ra = rd_base + AW'((l - rd_base[1:0]) & 3);
            wa = AW'(addr) + AW'((l - addr[1:0]) & 3);
        end
        assign rd_row[l] = ra[AW-1:2];
        assign wrow_mux  = clr_reg ? clr_cnt_reg[LW-1:0] : wa[AW-1:2];
        assign wr_row[l] = wrow_mux;
        mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .clk   (clk),
            .we    (clr_reg || wr_en[l]),
            .waddr (wrow_mux),
            .wdata (clr_reg ? 8'd0 : wr_byte[l]),
            .raddr (rd_row[l]),
            .rdata (rd_byte[l])
        );
    end

    // forwarding of the store issued in the same cycle as the read
    logic [3:0]    fw_hit_reg;
    logic [7:0]    fw_byte_reg [4];
    logic [7:0]    mem_byte [4];
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            fw_hit_reg[l]  <= wr_en[l] && (wr_row[l] == rd_row[l]);
            fw_byte_reg[l] <= wr_byte[l];
        end
    end
    always_comb
    begin
        for (int l = 0; l < 4; l++)
            mem_byte[l] = fw_hit_reg[l] ? fw_byte_reg[l] : rd_byte[l];
    end

    // big-endian assembly: byte k (k=0 most significant) at lane (addr+k)&3
    logic [7:0] bk [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            bk[k] = mem_byte[2'(addr[1:0] + 2'(k))];
        ld_raw = 32'd0;
        unique case (nbytes)
            3'd1:    ld_raw = {24'd0, bk[0]};
            3'd2:    ld_raw = {16'd0, bk[0], bk[1]};
            default: ld_raw = {bk[0], bk[1], bk[2], bk[3]};
        endcase
    end

    // store lanes
    always_comb
    begin
        logic [1:0] k;
        wr_en = 4'd0;
        for (int l = 0; l < 4; l++)
        begin
            k = 2'(l) - addr[1:0];
            wr_byte[l] = b[8*(3-k) +: 8];
            if (nbytes == 3'd2)
                wr_byte[l] = b[8*(1-k[0]) +: 8];
            else if (nbytes == 3'd1)
                wr_byte[l] = b[7:0];
            if (exec && is_store && (3'(k) < nbytes))
                wr_en[l] = 1'b1;
        end
    end

    always_comb
    begin
        status   = ST_OK;
        wr       = 1'b0;
        dst      = ex_reg.rt;
        val      = 32'd0;
        pc_next  = pc4;
        is_store = 1'b0;
        nbytes   = 3'd4;
        unique case (ex_reg.mode)
            OP_RTYPE:
            begin
                wr  = 1'b1;
                dst = ex_reg.rd;
                case (ex_reg.func)
                    FN_ADD, FN_ADDU: val = a + b;
                    FN_SUB:  val = a - b;
                    FN_AND:  val = a & b;
                    FN_OR:   val = a | b;
                    FN_XOR:  val = a ^ b;
                    FN_NOR:  val = ~(a | b);
                    FN_NAND: val = ~(a & b);
                    FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                    FN_SLL:  val = b << ex_reg.shamt;
                    FN_SRL:  val = b >> ex_reg.shamt;
                    FN_SRA:  val = $unsigned($signed(b) >>> ex_reg.shamt);
                    FN_JR:
                    begin
                        wr = 1'b0;
                        pc_next = a;
                    end
                    default:
                    begin
                        wr = 1'b0;
                        status = ST_UNKNOWN;
                    end
                endcase
            end
            OP_ADDI, OP_ADDIU: begin wr = 1'b1; val = a + simm; end
            OP_LW:  begin wr = 1'b1; nbytes = 3'd4; val = ld_raw; end
            OP_LH:  begin wr = 1'b1; nbytes = 3'd2; val = {{16{ld_raw[15]}}, ld_raw[15:0]}; end
            OP_LHU: begin wr = 1'b1; nbytes = 3'd2; val = ld_raw; end
            OP_LB:  begin wr = 1'b1; nbytes = 3'd1; val = {{24{ld_raw[7]}}, ld_raw[7:0]}; end
            OP_LBU: begin wr = 1'b1; nbytes = 3'd1; val = ld_raw; end
            OP_SW:  begin is_store = 1'b1; nbytes = 3'd4; end
            OP_SH:  begin is_store = 1'b1; nbytes = 3'd2; end
            OP_SB:  begin is_store = 1'b1; nbytes = 3'd1; end
            OP_LUI:  begin wr = 1'b1; val = {ex_reg.imm16, 16'd0}; end
            OP_ANDI: begin wr = 1'b1; val = a & zimm; end
            OP_ORI:  begin wr = 1'b1; val = a | zimm; end
            OP_NORI: begin wr = 1'b1; val = ~(a | zimm); end
            OP_SLTI: begin wr = 1'b1; val = {31'd0, $signed(a) < $signed(simm)}; end
            OP_BEQ:  if (a == b) pc_next = pc4 + {simm[29:0], 2'b00};
            OP_BNE:  if (a != b) pc_next = pc4 + {simm[29:0], 2'b00};
            OP_BGTZ: if (a != 32'd0 && !a[31]) pc_next = pc4 + {simm[29:0], 2'b00};
            OP_J:    pc_next = (pc4 & REGION_MASK) | {4'd0, ex_reg.target, 2'b00};
            OP_JAL:
            begin
                wr = 1'b1;
                dst = LINK_REG;
                val = pc4;
                pc_next = (pc4 & REGION_MASK) | {4'd0, ex_reg.target, 2'b00};
            end
            OP_HALT: status = ST_HALT;
            default: status = ST_UNKNOWN;
        endcase
        if (!wr || dst == 5'd0)
        begin
            wr  = 1'b0;
            dst = 5'd0;
            val = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            out_full_reg <= 1'b0;
            pc_reg       <= 32'd0;
            rf_vld_reg   <= 32'd0;
        end
        else
        begin
            if (!stall)
                ex_valid_reg <= accept;
            if (exec)
                out_full_reg <= 1'b1;
            else if (m_tready)
                out_full_reg <= 1'b0;
            if (cfg_wr)
                pc_reg <= pwdata;
            else if (exec)
                pc_reg <= pc_next;
            if (exec && wr)
                rf_vld_reg[dst] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ex_reg <= s_in;
        if (exec && wr)
            rf_reg[dst] <= val;
        if (exec)
        begin
            out_reg.status     <= status;
            out_reg.reg_write  <= wr;
            out_reg.dest_reg   <= dst;
            out_reg.dest_value <= val;
            out_reg.pc_value   <= pc_next;
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {8'd0, out_reg.pc_value, out_reg.dest_value, out_reg.dest_reg,
                       out_reg.reg_write, out_reg.status};
endmodule

// ===== hw/rtl/mse_checker.sv =====
// Port-level checker for mips_subset_execute, bound to the top level.
// Depends on mse_pkg, which it imports.
module mse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    import mse_pkg::*;

    // a result waiting on the output must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // status never takes the reserved code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("reserved status code");

    // no write reported means destination and value are zero
    a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[39:3] == 37'd0)
        else $error("dest fields set without register write");

    // a write never targets register zero
    a_r0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[7:3] != 5'd0)
        else $error("write to register zero reported");
endmodule

bind mips_subset_execute mse_checker u_mse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
